### rtl/core/brfifo_pkg.sv
`default_nettype none
package brfifo_pkg;

	localparam int PTR_W       = 10;
	localparam int BUFFER_SIZE = 1 << PTR_W;
	localparam int MAX_POP_RUN = 64;
	localparam int CNT_W       = 7;

	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_FIND  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_POP_REFUSED = 2'd1;
	localparam logic [1:0] STAT_DROPPED     = 2'd2;
	localparam logic [1:0] STAT_REFUSED     = 2'd3;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data_byte;
		logic [CNT_W-1:0] count;
		logic [9:0]       offset;
	} in_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       last;
		logic [1:0] status;
		logic [9:0] found_offset;
		logic [9:0] fill_level;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_RD,
		S_POP_OUT,
		S_FIND_RD,
		S_FIND_CMP,
		S_FIND_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic       load_item;
		logic       emit_simple;
		logic       pop_start;
		logic       rd_pop;
		logic       emit_pop;
		logic       find_start;
		logic       rd_find;
		logic       find_hit;
		logic       find_end;
		logic       find_adv;
		logic       emit_find;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       pop_refuse;
		logic       pop_zero;
		logic       find_skip;
		logic       match;
		logic       idx_end;
		logic       rem_last;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### rtl/core/brfifo_ctrl.sv
`default_nettype none
module brfifo_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire brfifo_pkg::dp_status_t  st,
	output brfifo_pkg::dp_cmd_t          cmd
);

	brfifo_pkg::ctrl_state_t state_q;
	brfifo_pkg::ctrl_state_t state_nxt;
	logic finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brfifo_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd    = '0;
		finish = 1'b0;
		case (state_q)
			brfifo_pkg::S_IDLE: begin
			end
			brfifo_pkg::S_EXEC: begin
				case (st.kind)
					brfifo_pkg::KIND_POP: begin
						if (st.pop_refuse || st.pop_zero) begin
							cmd.emit_simple = st.out_free;
							finish          = st.out_free;
						end else begin
							cmd.pop_start = 1'b1;
						end
					end
					brfifo_pkg::KIND_FIND: begin
						if (st.find_skip) begin
							cmd.emit_simple = st.out_free;
							finish          = st.out_free;
						end else begin
							cmd.find_start = 1'b1;
						end
					end
					default: begin
						cmd.emit_simple = st.out_free;
						finish          = st.out_free;
					end
				endcase
			end
			brfifo_pkg::S_POP_RD: begin
				cmd.rd_pop = 1'b1;
			end
			brfifo_pkg::S_POP_OUT: begin
				cmd.emit_pop = st.out_free;
				finish       = st.out_free && st.rem_last;
			end
			brfifo_pkg::S_FIND_RD: begin
				cmd.rd_find = 1'b1;
			end
			brfifo_pkg::S_FIND_CMP: begin
				if (st.match) begin
					cmd.find_hit = 1'b1;
				end else if (st.idx_end) begin
					cmd.find_end = 1'b1;
				end else begin
					cmd.find_adv = 1'b1;
				end
			end
			brfifo_pkg::S_FIND_OUT: begin
				cmd.emit_find = st.out_free;
				finish        = st.out_free;
			end
			default: begin
			end
		endcase
		cmd_ready     = (state_q == brfifo_pkg::S_IDLE) || finish;
		cmd.load_item = cmd_ready && cmd_valid;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			brfifo_pkg::S_EXEC: begin
				if (st.kind == brfifo_pkg::KIND_POP && !st.pop_refuse && !st.pop_zero) begin
					state_nxt = brfifo_pkg::S_POP_RD;
				end else if (st.kind == brfifo_pkg::KIND_FIND && !st.find_skip) begin
					state_nxt = brfifo_pkg::S_FIND_RD;
				end
			end
			brfifo_pkg::S_POP_RD: begin
				state_nxt = brfifo_pkg::S_POP_OUT;
			end
			brfifo_pkg::S_POP_OUT: begin
				if (st.out_free && !st.rem_last) begin
					state_nxt = brfifo_pkg::S_POP_RD;
				end
			end
			brfifo_pkg::S_FIND_RD: begin
				state_nxt = brfifo_pkg::S_FIND_CMP;
			end
			brfifo_pkg::S_FIND_CMP: begin
				if (st.match || st.idx_end) begin
					state_nxt = brfifo_pkg::S_FIND_OUT;
				end else begin
					state_nxt = brfifo_pkg::S_FIND_RD;
				end
			end
			default: begin
			end
		endcase
		if (cmd_ready) begin
			state_nxt = cmd_valid ? brfifo_pkg::S_EXEC : brfifo_pkg::S_IDLE;
		end
	end

endmodule
`default_nettype wire

### rtl/core/brfifo_dp.sv
`default_nettype none
module brfifo_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire brfifo_pkg::in_t        cmd_data,
	input  wire logic                   overwrite_when_full,
	input  wire brfifo_pkg::dp_cmd_t    cmd,
	output brfifo_pkg::dp_status_t      st,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output brfifo_pkg::out_t            rsp_data
);

	logic [7:0] mem [brfifo_pkg::BUFFER_SIZE];

	brfifo_pkg::in_t  item_q;
	brfifo_pkg::ptr_t wp_q;
	brfifo_pkg::ptr_t rp_q;
	brfifo_pkg::ptr_t pos_q;
	brfifo_pkg::ptr_t idx_q;
	brfifo_pkg::ptr_t found_q;
	brfifo_pkg::ptr_t after_q;
	logic [brfifo_pkg::CNT_W-1:0] rem_q;
	logic [7:0] rd_data_q;
	logic       out_valid_q;
	brfifo_pkg::out_t out_q;

	brfifo_pkg::ptr_t fill;
	logic             full;
	logic             push_wr;
	logic             push_drop;
	logic             rd_en;
	brfifo_pkg::ptr_t rd_addr;
	brfifo_pkg::out_t simple_res;
	brfifo_pkg::out_t out_nxt;
	logic             emit;

	assign fill      = wp_q - rp_q;
	assign full      = (fill == brfifo_pkg::PTR_W'(brfifo_pkg::BUFFER_SIZE - 1));
	assign push_wr   = cmd.emit_simple && (item_q.kind == brfifo_pkg::KIND_PUSH)
		&& (!full || overwrite_when_full);
	assign push_drop = push_wr && full;
	assign rd_en     = cmd.rd_pop || cmd.rd_find;
	assign rd_addr   = cmd.rd_pop ? rp_q : pos_q;
	assign emit      = cmd.emit_simple || cmd.emit_pop || cmd.emit_find;

	assign st.kind       = item_q.kind;
	assign st.pop_refuse = (item_q.count > brfifo_pkg::CNT_W'(brfifo_pkg::MAX_POP_RUN))
		|| (brfifo_pkg::PTR_W'(item_q.count) > fill);
	assign st.pop_zero   = (item_q.count == '0);
	assign st.find_skip  = (item_q.offset >= fill);
	assign st.match      = (rd_data_q == item_q.data_byte);
	assign st.idx_end    = ((idx_q + brfifo_pkg::PTR_W'(1)) == fill);
	assign st.rem_last   = (rem_q == brfifo_pkg::CNT_W'(1));
	assign st.out_free   = !out_valid_q || !rsp_stall;

	always_comb begin
		simple_res = '0;
		simple_res.last = 1'b1;
		case (item_q.kind)
			brfifo_pkg::KIND_PUSH: begin
				if (full) begin
					simple_res.status = overwrite_when_full ? brfifo_pkg::STAT_DROPPED
						: brfifo_pkg::STAT_REFUSED;
					simple_res.fill_level = fill;
				end else begin
					simple_res.status     = brfifo_pkg::STAT_OK;
					simple_res.fill_level = fill + brfifo_pkg::PTR_W'(1);
				end
			end
			brfifo_pkg::KIND_POP: begin
				simple_res.status = st.pop_refuse ? brfifo_pkg::STAT_POP_REFUSED
					: brfifo_pkg::STAT_OK;
				simple_res.fill_level = fill;
			end
			brfifo_pkg::KIND_FIND: begin
				simple_res.found_offset = fill;
				simple_res.fill_level   = fill;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_nxt = simple_res;
		if (cmd.emit_pop) begin
			out_nxt              = '0;
			out_nxt.read_byte    = rd_data_q;
			out_nxt.last         = st.rem_last;
			out_nxt.fill_level   = after_q;
		end else if (cmd.emit_find) begin
			out_nxt              = '0;
			out_nxt.last         = 1'b1;
			out_nxt.found_offset = found_q;
			out_nxt.fill_level   = fill;
		end
	end

	always_ff @(posedge clk) begin
		if (push_wr) begin
			mem[wp_q] <= item_q.data_byte;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_simple && item_q.kind == brfifo_pkg::KIND_CLEAR) begin
				wp_q <= '0;
				rp_q <= '0;
			end else begin
				if (push_wr) begin
					wp_q <= wp_q + brfifo_pkg::PTR_W'(1);
				end
				if (push_drop || cmd.emit_pop) begin
					rp_q <= rp_q + brfifo_pkg::PTR_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= cmd_data;
		end
		if (cmd.pop_start) begin
			rem_q   <= item_q.count;
			after_q <= fill - brfifo_pkg::PTR_W'(item_q.count);
		end else if (cmd.emit_pop) begin
			rem_q <= rem_q - brfifo_pkg::CNT_W'(1);
		end
		if (cmd.find_start) begin
			pos_q <= rp_q + item_q.offset;
			idx_q <= item_q.offset;
		end else if (cmd.find_adv) begin
			pos_q <= pos_q + brfifo_pkg::PTR_W'(1);
			idx_q <= idx_q + brfifo_pkg::PTR_W'(1);
		end
		if (cmd.find_hit) begin
			found_q <= idx_q;
		end else if (cmd.find_end) begin
			found_q <= fill;
		end
		if (emit) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule
`default_nettype wire

### rtl/core/byte_ring_fifo_with_search_top.sv
// Byte FIFO in a 1024 x 8 ring memory (one write port, one registered read port, contents
// undefined after reset and never cleared; capacity 1023 bytes). Each command beat is taken
// into a holding register and gives its results through an output register. Push, clear, a
// refused or zero-length pop and a find whose offset is at or past the fill level finish in
// the execute state, so back-to-back beats of these kinds run at one per cycle while the
// result port does not stall. A pop run passes through the execute state, then a registered
// memory read state and a result state for each byte; a find passes through the execute
// state, then a registered memory read state and a compare state for each byte it examines,
// and one more state to post its result. The result of a command that ends in its execute
// state appears in the cycle after it; a stalled result port holds the engine.
`default_nettype none
module byte_ring_fifo_with_search_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire brfifo_pkg::in_t  cmd_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output brfifo_pkg::out_t      rsp_data,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic                   ovw_q;
	logic                   cmd_ready;
	brfifo_pkg::dp_cmd_t    cmd;
	brfifo_pkg::dp_status_t st;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == 1'b0) ? {31'b0, ovw_q} : 32'b0;
	assign cmd_stall = !cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovw_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			ovw_q <= pwdata[0];
		end
	end

	brfifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.st        (st),
		.cmd       (cmd)
	);

	brfifo_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_data            (cmd_data),
		.overwrite_when_full (ovw_q),
		.cmd                 (cmd),
		.st                  (st),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.rsp_data            (rsp_data)
	);

	a_refused_pop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == brfifo_pkg::STAT_POP_REFUSED
		|-> rsp_data.last && rsp_data.read_byte == 8'd0)
		else $error("refused pop result malformed");

	a_non_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last |-> rsp_data.status == brfifo_pkg::STAT_OK)
		else $error("non-final result with non-ok status");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.found_offset <= rsp_data.fill_level)
		else $error("found offset beyond fill level");

	a_pop_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pop && !st.rem_last |-> cmd_stall)
		else $error("command taken in the middle of a pop run");

endmodule
`default_nettype wire

### verif/byte_ring_fifo_with_search_top_tb.sv
module byte_ring_fifo_with_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import brfifo_pkg::*;

	localparam int STUCK_LIMIT = 10000;
	localparam int TAIL_CYCLES = 8;
	localparam int REPORT_MAX = 10;
	localparam int FULL_LEVEL = BUFFER_SIZE - 1;
	localparam logic [2:0] REG_OVERWRITE = 3'd0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	in_t         cmd_data;
	logic        rsp_valid;
	logic        rsp_stall;
	out_t        rsp_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [7:0] ring_bytes [BUFFER_SIZE];
	ptr_t       wr_ptr = '0;
	ptr_t       rd_ptr = '0;
	logic       drop_oldest = 1'b1;
	out_t       pending_results [$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;
	int mismatches = 0;
	int cmds_sent = 0;
	int beats_seen = 0;
	int drops_seen = 0;
	int push_refusals = 0;
	int pop_refusals = 0;

	byte_ring_fifo_with_search_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5ns clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	function automatic out_t result_beat(input logic [7:0] rb, input logic lst,
			input logic [1:0] st, input logic [9:0] found, input logic [9:0] level);
		out_t r;
		r.read_byte    = rb;
		r.last         = lst;
		r.status       = st;
		r.found_offset = found;
		r.fill_level   = level;
		return r;
	endfunction

	task automatic predict_fifo_step(input in_t c);
		ptr_t       level;
		ptr_t       after;
		ptr_t       found;
		ptr_t       pos;
		logic [1:0] st;
		level = wr_ptr - rd_ptr;
		case (c.kind)
			KIND_PUSH: begin
				st = STAT_OK;
				if (level == ptr_t'(FULL_LEVEL)) begin
					if (drop_oldest) begin
						ring_bytes[wr_ptr] = c.data_byte;
						wr_ptr++;
						rd_ptr++;
						st = STAT_DROPPED;
						drops_seen++;
					end else begin
						st = STAT_REFUSED;
						push_refusals++;
					end
				end else begin
					ring_bytes[wr_ptr] = c.data_byte;
					wr_ptr++;
				end
				after = wr_ptr - rd_ptr;
				pending_results.push_back(result_beat(8'h00, 1'b1, st, 10'd0, after));
			end
			KIND_POP: begin
				if (c.count > MAX_POP_RUN || c.count > level) begin
					pop_refusals++;
					pending_results.push_back(
						result_beat(8'h00, 1'b1, STAT_POP_REFUSED, 10'd0, level));
				end else if (c.count == 0) begin
					pending_results.push_back(result_beat(8'h00, 1'b1, STAT_OK, 10'd0, level));
				end else begin
					after = level - c.count;
					for (int i = 0; i < c.count; i++) begin
						pending_results.push_back(result_beat(ring_bytes[rd_ptr],
							i == c.count - 1, STAT_OK, 10'd0, after));
						rd_ptr++;
					end
				end
			end
			KIND_FIND: begin
				found = level;
				if (c.offset < level) begin
					pos = rd_ptr + c.offset;
					for (int i = c.offset; i < level; i++) begin
						if (ring_bytes[pos] == c.data_byte) begin
							found = ptr_t'(i);
							break;
						end
						pos++;
					end
				end
				pending_results.push_back(result_beat(8'h00, 1'b1, STAT_OK, found, level));
			end
			default: begin
				wr_ptr = '0;
				rd_ptr = '0;
				pending_results.push_back(result_beat(8'h00, 1'b1, STAT_OK, 10'd0, 10'd0));
			end
		endcase
	endtask

	task automatic send_beat(input in_t c);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd_data  = c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		cmds_sent++;
		predict_fifo_step(c);
	endtask

	function automatic in_t make_cmd(input logic [1:0] k, input logic [7:0] d,
			input logic [6:0] n, input logic [9:0] off);
		in_t c;
		c.kind      = k;
		c.data_byte = d;
		c.count     = n;
		c.offset    = off;
		return c;
	endfunction

	task automatic push_byte(input logic [7:0] d);
		send_beat(make_cmd(KIND_PUSH, d, 7'($urandom), 10'($urandom)));
	endtask

	task automatic pop_run(input logic [6:0] n);
		send_beat(make_cmd(KIND_POP, 8'($urandom), n, 10'($urandom)));
	endtask

	task automatic find_byte(input logic [7:0] d, input logic [9:0] off);
		send_beat(make_cmd(KIND_FIND, d, 7'($urandom), off));
	endtask

	task automatic clear_fifo();
		send_beat(make_cmd(KIND_CLEAR, 8'($urandom), 7'($urandom), 10'($urandom)));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		value = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_overwrite_reg();
		logic [31:0] value;
		apb_read(REG_OVERWRITE, value);
		if (value[0] !== drop_oldest) begin
			flag_mismatch("overwrite_when_full readback", 32'(drop_oldest), value);
		end
	endtask

	task automatic set_overwrite(input logic v);
		apb_write(REG_OVERWRITE, {31'd0, v});
		drop_oldest = v;
		check_overwrite_reg();
	endtask

	task automatic test_register_reset();
		check_overwrite_reg();
	endtask

	task automatic test_directed();
		clear_fifo();
		pop_run(7'd1);
		pop_run(7'd0);
		find_byte(8'h00, 10'd0);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hA5);
		push_byte(8'h5A);
		find_byte(8'hA5, 10'd0);
		find_byte(8'hA5, 10'd3);
		find_byte(8'h33, 10'd0);
		find_byte(8'h00, 10'd1023);
		pop_run(7'd5);
		pop_run(7'd127);
		pop_run(7'd65);
		pop_run(7'd0);
		pop_run(7'd2);
		push_byte(8'h80);
		pop_run(7'd3);
		push_byte(8'h7F);
		clear_fifo();
		find_byte(8'h7F, 10'd0);
	endtask

	task automatic test_full_policies();
		logic [7:0] needle;
		wait_drained();
		set_overwrite(1'b1);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		clear_fifo();
		repeat (FULL_LEVEL) push_byte(8'($urandom));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (6) push_byte(8'($urandom));
		needle = ring_bytes[rd_ptr + ptr_t'(1000)];
		find_byte(needle, 10'd990);
		find_byte(8'($urandom), 10'd1022);
		find_byte(8'($urandom), 10'd1023);
		wait_drained();
		set_overwrite(1'b0);
		repeat (4) push_byte(8'($urandom));
		find_byte(8'($urandom), 10'd0);
		repeat (15) pop_run(7'd64);
		pop_run(7'd64);
		push_byte(8'($urandom));
		pop_run(7'd64);
		pop_run(7'd1);
		wait_drained();
		set_overwrite(1'b1);
	endtask

	task automatic test_stall_backlog();
		wait_drained();
		tx_idle = 1'b0;
		clear_fifo();
		rx_hold = 120;
		for (int i = 0; i < 30; i++) begin
			if (i % 5 == 4) begin
				pop_run(7'd2);
			end else begin
				push_byte(8'($urandom));
			end
		end
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_mix(input int n_cmds, input int push_pct);
		ptr_t       level;
		int         pick;
		int         top;
		logic [7:0] needle;
		logic [9:0] start;
		for (int i = 0; i < n_cmds; i++) begin
			if (i % 60 == 59) begin
				wait_drained();
			end
			level = wr_ptr - rd_ptr;
			pick = $urandom_range(0, 99);
			top = (level < MAX_POP_RUN) ? int'(level) : MAX_POP_RUN;
			if (pick < push_pct) begin
				push_byte(8'($urandom));
			end else if (pick < push_pct + (100 - push_pct) * 45 / 100) begin
				if (top == 0 || $urandom_range(0, 9) == 0) begin
					pop_run(7'($urandom));
				end else if ($urandom_range(0, 3) == 0) begin
					pop_run(7'($urandom_range(1, top)));
				end else begin
					pop_run(7'($urandom_range(1, (top < 4) ? top : 4)));
				end
			end else if (pick < 97) begin
				needle = 8'($urandom);
				if (level != 0 && $urandom_range(0, 2) != 0) begin
					needle = ring_bytes[rd_ptr + ptr_t'($urandom_range(0, level - 1))];
				end
				if (level == 0 || $urandom_range(0, 7) == 0) begin
					start = 10'($urandom);
				end else begin
					start = 10'($urandom_range(0, level - 1));
				end
				find_byte(needle, start);
			end else begin
				clear_fifo();
			end
		end
	endtask

	initial begin : rx_side
		int rx_wait;
		rx_wait = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
			end
			@(negedge clk);
			if (rx_hold > 0) begin
				rsp_stall = 1'b1;
				rx_hold--;
			end else if (rx_wait > 0) begin
				rsp_stall = 1'b1;
				rx_wait--;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			beats_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result beat", 32'd0, 32'(rsp_data));
			end else begin
				want = pending_results.pop_front();
				if (rsp_data.read_byte !== want.read_byte) begin
					flag_mismatch("read_byte", 32'(want.read_byte), 32'(rsp_data.read_byte));
				end
				if (rsp_data.last !== want.last) begin
					flag_mismatch("last", 32'(want.last), 32'(rsp_data.last));
				end
				if (rsp_data.status !== want.status) begin
					flag_mismatch("status", 32'(want.status), 32'(rsp_data.status));
				end
				if (rsp_data.found_offset !== want.found_offset) begin
					flag_mismatch("found_offset", 32'(want.found_offset),
						32'(rsp_data.found_offset));
				end
				if (rsp_data.fill_level !== want.fill_level) begin
					flag_mismatch("fill_level", 32'(want.fill_level),
						32'(rsp_data.fill_level));
				end
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
					(rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
		$display("byte_ring_fifo_with_search_top_tb failed");
		$finish;
	end

	initial begin : main
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_directed();
		test_full_policies();
		test_stall_backlog();

		wait_drained();
		set_overwrite(1'b0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_random_mix(150, 65);

		wait_drained();
		set_overwrite(1'b1);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random_mix(150, 50);

		wait_drained();
		set_overwrite(1'b0);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		test_random_mix(150, 55);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("covered %0d commands, %0d result beats, %0d oldest-byte drops,",
			cmds_sent, beats_seen, drops_seen);
		$display("%0d refused pushes, %0d refused pop runs, under both full policies",
			push_refusals, pop_refusals);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("byte_ring_fifo_with_search_top_tb passed");
		end else begin
			$display("byte_ring_fifo_with_search_top_tb failed");
		end
		$finish;
	end

endmodule
